### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Check that a condition implies another in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### hdl/lfu_bbc_pkg.sv
// ----------------------------------------------------------------------------
// LFU byte budget cache policy package
// Operation codes, result kinds, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package lfu_bbc_pkg;

	localparam int KEY_W        = 32;
	localparam int COUNT_W      = 16;
	localparam int SLOT_W       = 5;
	localparam int FIELD_SIZE_W = 16;
	localparam int BYTES_W      = 20;

	localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
	localparam logic [BYTES_W-1:0] BUDGET_RESET = 20'd4096;

	typedef enum logic [1:0] {
		OP_FETCH  = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_FETCH  = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_EVICT  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_DECIDE,
		ST_CHECK,
		ST_MIN,
		ST_EVICT,
		ST_PLACE
	} state_t;

endpackage

`default_nettype wire

### hdl/lfu_byte_budget_cache_policy.sv
// ----------------------------------------------------------------------------
// LFU byte budget cache policy
// Keyed entry table with use counts under a byte budget: fetch, insert with
// least-used eviction, and remove.
// ----------------------------------------------------------------------------
// Every fetch, insert and remove walks the entry memory one slot per cycle
// through its single registered read port, so the slot scan sets the latency.
// A fetch or a remove scans for its key, then presents its result. An insert
// scans for its key, checks the fit and places the entry if nothing is
// evicted; each eviction adds a fit check, a least-used scan and a notice. A
// result that is not taken stalls the sequencer; the block takes no new
// request until the last result of the current one is in the output register.
// Operation code 3 is accepted and dropped without a result.
`default_nettype none

module lfu_byte_budget_cache_policy
	import lfu_bbc_pkg::*;
#(
	parameter int ENTRIES   = 32,
	parameter int SIZE_BITS = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// configuration
	input  wire logic                    cfg_wr_en,
	input  wire logic [BYTES_W-1:0]      cfg_wr_data,
	// request channel
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [1:0]              op,
	input  wire logic [KEY_W-1:0]        key,
	input  wire logic [FIELD_SIZE_W-1:0] doc_size,
	// result channel
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [1:0]                   kind,
	output logic                         ok,
	output logic [KEY_W-1:0]             out_key,
	output logic [SLOT_W-1:0]            slot,
	output logic [COUNT_W-1:0]           use_count,
	output logic [FIELD_SIZE_W-1:0]      entry_size,
	output logic                         last
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int SW = (SIZE_BITS < FIELD_SIZE_W) ? SIZE_BITS : FIELD_SIZE_W;
	localparam int DW = KEY_W + COUNT_W + SW;
	localparam int CMP_W = COUNT_W + KEY_W;
	localparam logic [CW-1:0] SCAN_END = CW'(ENTRIES);

	state_t state_q, state_d;

	// request registers
	op_t                 op_q;
	logic [KEY_W-1:0]    key_q;
	logic [SW-1:0]       size_q;

	// policy state
	logic [BYTES_W-1:0]  budget_q;
	logic [BYTES_W-1:0]  used_q;
	logic [ENTRIES-1:0]  valid_q;

	// scan pointer and read pipeline
	logic [CW-1:0]       idx_q;
	logic                rd_s1;
	logic [IW-1:0]       idx_s1;

	// lookup results
	logic                hit_q;
	logic [IW-1:0]       hit_idx_q;
	logic [COUNT_W-1:0]  hit_cnt_q;
	logic [SW-1:0]       hit_bytes_q;
	logic                free_q;
	logic [IW-1:0]       free_idx_q;

	// least-used candidate
	logic                best_q;
	logic [IW-1:0]       best_idx_q;
	logic [KEY_W-1:0]    best_key_q;
	logic [COUNT_W-1:0]  best_cnt_q;
	logic [SW-1:0]       best_bytes_q;

	// output register
	logic                out_valid_q;
	logic [1:0]          kind_q;
	logic                ok_q;
	logic [KEY_W-1:0]    out_key_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [COUNT_W-1:0]  use_count_q;
	logic [FIELD_SIZE_W-1:0] entry_size_q;
	logic                last_q;

	// memory interface
	logic                mem_we;
	logic [IW-1:0]       mem_waddr;
	logic [DW-1:0]       mem_wdata;
	logic [DW-1:0]       rd_data;
	logic [KEY_W-1:0]    rd_key;
	logic [COUNT_W-1:0]  rd_cnt;
	logic [SW-1:0]       rd_bytes;
	logic                rd_live;

	// shared comparator
	logic [CMP_W-1:0]    cmp_a, cmp_b;
	logic                cmp_lt, cmp_eq;

	// control
	logic                accept;
	logic                slot_free;
	logic                scan_issue;
	logic                scan_done;
	logic                reject;
	logic                need_room;
	logic [BYTES_W:0]    fit_sum;
	logic [COUNT_W-1:0]  hit_cnt_inc;

	logic                drop_en;
	logic [IW-1:0]       drop_idx;
	logic [SW-1:0]       drop_bytes;
	logic [BYTES_W-1:0]  drop_bytes_w;
	logic [BYTES_W-1:0]  used_after_drop;
	logic                place_en;
	logic [IW-1:0]       place_idx;

	logic                emit_en;
	kind_t               emit_kind;
	logic                emit_ok;
	logic [KEY_W-1:0]    emit_key;
	logic [IW-1:0]       emit_idx;
	logic [COUNT_W-1:0]  emit_cnt;
	logic [FIELD_SIZE_W-1:0] emit_size;
	logic                emit_last;
	logic [IW+SLOT_W-1:0] emit_slot_w;

	lfu_bbc_table #(
		.DEPTH (ENTRIES),
		.AW    (IW),
		.DW    (DW)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (scan_issue),
		.raddr (idx_q[IW-1:0]),
		.rdata (rd_data)
	);

	assign rd_key   = rd_data[DW-1 -: KEY_W];
	assign rd_cnt   = rd_data[SW +: COUNT_W];
	assign rd_bytes = rd_data[SW-1:0];
	assign rd_live  = valid_q[idx_s1];

	// compare keys during lookup, {count, key} against the candidate during the min scan
	always_comb begin
		if (state_q == ST_MIN) begin
			cmp_a = {rd_cnt, rd_key};
			cmp_b = {best_cnt_q, best_key_q};
		end else begin
			cmp_a = {{COUNT_W{1'b0}}, rd_key};
			cmp_b = {{COUNT_W{1'b0}}, key_q};
		end
	end

	assign cmp_lt = cmp_a < cmp_b;
	assign cmp_eq = cmp_a == cmp_b;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign slot_free  = !out_valid_q || out_ready;
	assign scan_issue = ((state_q == ST_LOOKUP) || (state_q == ST_MIN)) && (idx_q != SCAN_END);
	assign scan_done  = ((state_q == ST_LOOKUP) || (state_q == ST_MIN)) && (idx_q == SCAN_END);
	assign reject     = BYTES_W'(size_q) > budget_q;
	assign fit_sum    = {1'b0, used_q} + (BYTES_W+1)'(size_q);
	assign need_room  = (fit_sum > {1'b0, budget_q}) || !free_q;
	assign hit_cnt_inc = (hit_cnt_q == COUNT_MAX) ? hit_cnt_q : hit_cnt_q + 1'b1;
	assign place_idx  = free_q ? free_idx_q : '0;
	assign drop_bytes_w = BYTES_W'(drop_bytes);
	assign used_after_drop = (used_q >= drop_bytes_w) ? used_q - drop_bytes_w : '0;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (op_t'(op) != OP_NOP)) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (scan_done) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (op_q == OP_INSERT && !reject) begin
					state_d = ST_CHECK;
				end else if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_CHECK: begin
				if (need_room && (|valid_q)) begin
					state_d = ST_MIN;
				end else begin
					state_d = ST_PLACE;
				end
			end
			ST_MIN: begin
				if (scan_done) begin
					state_d = ST_EVICT;
				end
			end
			ST_EVICT: begin
				if (slot_free) begin
					state_d = ST_CHECK;
				end
			end
			ST_PLACE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// per-state actions: results, drops, memory writes
	always_comb begin
		emit_en    = 1'b0;
		emit_kind  = KIND_FETCH;
		emit_ok    = 1'b0;
		emit_key   = key_q;
		emit_idx   = '0;
		emit_cnt   = '0;
		emit_size  = '0;
		emit_last  = 1'b1;
		drop_en    = 1'b0;
		drop_idx   = hit_idx_q;
		drop_bytes = hit_bytes_q;
		mem_we     = 1'b0;
		mem_waddr  = hit_idx_q;
		mem_wdata  = {key_q, hit_cnt_inc, hit_bytes_q};
		place_en   = 1'b0;
		case (state_q)
			ST_DECIDE: begin
				case (op_q)
					OP_FETCH: begin
						emit_en   = slot_free;
						emit_kind = KIND_FETCH;
						emit_ok   = hit_q;
						if (hit_q) begin
							emit_idx  = hit_idx_q;
							emit_cnt  = hit_cnt_inc;
							emit_size = FIELD_SIZE_W'(hit_bytes_q);
							mem_we    = slot_free;
						end
					end
					OP_REMOVE: begin
						emit_en   = slot_free;
						emit_kind = KIND_REMOVE;
						emit_ok   = hit_q;
						if (hit_q) begin
							emit_idx  = hit_idx_q;
							emit_cnt  = hit_cnt_q;
							emit_size = FIELD_SIZE_W'(hit_bytes_q);
							drop_en   = slot_free;
						end
					end
					OP_INSERT: begin
						if (reject) begin
							emit_en   = slot_free;
							emit_kind = KIND_INSERT;
							emit_size = FIELD_SIZE_W'(size_q);
						end else begin
							// re-insert: free the old entry silently
							drop_en = hit_q;
						end
					end
					default: begin
						emit_en = 1'b0;
					end
				endcase
			end
			ST_EVICT: begin
				emit_en    = slot_free;
				emit_kind  = KIND_EVICT;
				emit_ok    = 1'b1;
				emit_key   = best_key_q;
				emit_idx   = best_idx_q;
				emit_cnt   = best_cnt_q;
				emit_size  = FIELD_SIZE_W'(best_bytes_q);
				emit_last  = 1'b0;
				drop_en    = slot_free;
				drop_idx   = best_idx_q;
				drop_bytes = best_bytes_q;
			end
			ST_PLACE: begin
				emit_en   = slot_free;
				emit_kind = KIND_INSERT;
				emit_ok   = 1'b1;
				emit_idx  = place_idx;
				emit_cnt  = COUNT_W'(1);
				emit_size = FIELD_SIZE_W'(size_q);
				place_en  = slot_free;
				mem_we    = slot_free;
				mem_waddr = place_idx;
				mem_wdata = {key_q, COUNT_W'(1), size_q};
			end
			default: begin
				emit_en = 1'b0;
			end
		endcase
	end

	assign emit_slot_w = (IW+SLOT_W)'(emit_idx);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// budget register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= BUDGET_RESET;
		end else if (cfg_wr_en) begin
			budget_q <= cfg_wr_data;
		end
	end

	// capture the request
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_t'(op);
			key_q  <= key;
			size_q <= doc_size[SW-1:0];
		end
	end

	// advance the scan pointer, rewind it between scans
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= scan_issue;
			if (scan_issue) begin
				idx_q <= idx_q + 1'b1;
			end else if (state_q == ST_IDLE || state_q == ST_CHECK) begin
				idx_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q[IW-1:0];
	end

	// entry valid bits and byte total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			used_q  <= '0;
		end else begin
			if (drop_en) begin
				valid_q[drop_idx] <= 1'b0;
				used_q            <= used_after_drop;
			end else if (place_en) begin
				valid_q[place_idx] <= 1'b1;
				used_q             <= used_q + BYTES_W'(size_q);
			end
		end
	end

	// lookup: first key match and lowest free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else begin
			if (accept) begin
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (rd_s1 && state_q == ST_LOOKUP) begin
				if (rd_live && cmp_eq && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (!rd_live && !free_q) begin
					free_q <= 1'b1;
				end
			end else if (drop_en && (!free_q || drop_idx < free_idx_q)) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_s1 && state_q == ST_LOOKUP) begin
			if (rd_live && cmp_eq && !hit_q) begin
				hit_idx_q   <= idx_s1;
				hit_cnt_q   <= rd_cnt;
				hit_bytes_q <= rd_bytes;
			end
			if (!rd_live && !free_q) begin
				free_idx_q <= idx_s1;
			end
		end else if (drop_en && (!free_q || drop_idx < free_idx_q)) begin
			free_idx_q <= drop_idx;
		end
	end

	// min scan: keep the least-used entry, lowest key on a tie
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= 1'b0;
		end else if (state_q == ST_CHECK) begin
			best_q <= 1'b0;
		end else if (rd_s1 && state_q == ST_MIN && rd_live && (!best_q || cmp_lt)) begin
			best_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_s1 && state_q == ST_MIN && rd_live && (!best_q || cmp_lt)) begin
			best_idx_q   <= idx_s1;
			best_key_q   <= rd_key;
			best_cnt_q   <= rd_cnt;
			best_bytes_q <= rd_bytes;
		end
	end

	// output register: load on emit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) begin
			kind_q       <= emit_kind;
			ok_q         <= emit_ok;
			out_key_q    <= emit_key;
			slot_q       <= emit_slot_w[SLOT_W-1:0];
			use_count_q  <= emit_cnt;
			entry_size_q <= emit_size;
			last_q       <= emit_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign ok         = ok_q;
	assign out_key    = out_key_q;
	assign slot       = slot_q;
	assign use_count  = use_count_q;
	assign entry_size = entry_size_q;
	assign last       = last_q;

endmodule

`default_nettype wire

### hdl/lfu_bbc_table.sv
// ----------------------------------------------------------------------------
// LFU entry table
// Single-port write, single-port read memory with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_bbc_table #(
	parameter int DEPTH = 32,
	parameter int AW    = 5,
	parameter int DW    = 64
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### hdl/lfu_bbc_checker.sv
// ----------------------------------------------------------------------------
// LFU byte budget cache policy checker
// Port-level checks on request sequencing and result framing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lfu_bbc_checker
	import lfu_bbc_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic [1:0]         op,
	input wire logic               out_valid,
	input wire logic [1:0]         kind,
	input wire logic               ok,
	input wire logic [COUNT_W-1:0] use_count,
	input wire logic               last
);

	// mid-request results keep the request port closed
	`ASSERT_SAME(a_busy_mid_request, clk, arst_n, out_valid && !last, !in_ready)

	// an eviction notice is always ok and never closes a request
	`ASSERT_SAME(a_evict_framing, clk, arst_n, out_valid && (kind == KIND_EVICT), ok && !last)

	// fetch and remove answers are single results
	`ASSERT_SAME(a_single_answer, clk, arst_n, out_valid && ((kind == KIND_FETCH) || (kind == KIND_REMOVE)), last)

	// an accepted insert stores at count one and closes the request
	`ASSERT_SAME(a_insert_count, clk, arst_n, out_valid && (kind == KIND_INSERT) && ok, (use_count == 16'd1) && last)

	// a real request takes the sequencer out of idle
	`ASSERT_NEXT(a_request_busy, clk, arst_n, in_valid && in_ready && (op != OP_NOP), !in_ready)

endmodule

bind lfu_byte_budget_cache_policy lfu_bbc_checker u_lfu_bbc_checker (.*);

`default_nettype wire
